// ----- hw/rtl/elev_pkg.sv -----
// shared types and codes for the elevator nearest-request scheduler
// no dependencies; used by elevator_nearest_request_scheduler_top
package elev_pkg;

    // width of the floor fields on the ports
    localparam int FLOOR_W = 4;

    typedef logic [FLOOR_W-1:0] floor_t;
    typedef logic signed [1:0]  dir_t;

    // travel direction codes
    localparam dir_t DIR_IDLE = 2'sd0;
    localparam dir_t DIR_UP   = 2'sd1;
    localparam dir_t DIR_DOWN = -2'sd1;

    // command codes
    typedef enum logic
    {
        CMD_STEP = 1'b0,
        CMD_CALL = 1'b1
    } cmd_t;

endpackage

// ----- hw/rtl/elevator_nearest_request_scheduler_top.sv -----
// elevator car controller: request bitmap, nearest-request target choice
// depends on elev_pkg (floor and direction types, command codes)
//
// usage
//   input channel (in_valid / in_stall) carries one word per event:
//     command = call  -> sets the request bit of call_floor (ignored when
//                        call_floor is not below FLOORS)
//     command = step  -> picks a target, opens doors there or moves one floor
//   output channel (out_valid / out_stall) returns exactly one word per input
//   word: car floor, travel direction, doors flag and the chosen target
//   the word passes through the input register, then the target search and the
//   state update land in the output register
//   throughput is one word per cycle while out_stall is low; the whole search
//   is a pair of priority encoders over the request bitmap
//   when out_stall is high and the output register is full, the output word holds,
//   the input register keeps its word and in_stall rises only if it is occupied
//   reset clears the request bitmap, puts the car at floor 0 with direction
//   idle and empties both registers; no clearing pass is needed
module elevator_nearest_request_scheduler_top #(
    parameter int FLOORS = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    // input channel
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic                        command,
    input  logic [elev_pkg::FLOOR_W-1:0] call_floor,
    // output channel
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [elev_pkg::FLOOR_W-1:0] car_floor,
    output logic signed [1:0]           travel_dir,
    output logic                        doors_opened,
    output logic                        target_valid,
    output logic [elev_pkg::FLOOR_W-1:0] target_floor
);

    // only floors reachable by a call word can ever hold a request
    localparam int REQ = (FLOORS < (1 << elev_pkg::FLOOR_W)) ? FLOORS
                                                              : (1 << elev_pkg::FLOOR_W);

    // input register
    logic                 s1_valid_reg;
    logic                 s1_valid_next;
    elev_pkg::cmd_t       s1_cmd_reg;
    elev_pkg::floor_t     s1_call_reg;

    // car state
    logic [REQ-1:0]       pending_reg;
    logic [REQ-1:0]       pending_next;
    elev_pkg::floor_t     floor_reg;
    elev_pkg::floor_t     floor_next;
    elev_pkg::dir_t       dir_reg;
    elev_pkg::dir_t       dir_next;

    // output register
    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic                 opened_reg;
    logic                 opened_next;
    logic                 found_reg;
    logic                 found_next;
    elev_pkg::floor_t     target_reg;
    elev_pkg::floor_t     target_next;

    logic                 advance;

    // search results
    logic [REQ-1:0]       ge_mask;
    logic [REQ-1:0]       le_mask;
    logic                 above_hit;
    logic                 below_hit;
    elev_pkg::floor_t     above_floor;
    elev_pkg::floor_t     below_floor;
    elev_pkg::floor_t     dist_up;
    elev_pkg::floor_t     dist_dn;
    logic                 pick_above;

    // handshake: the input word moves on whenever the output slot frees up
    assign advance  = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = s1_valid_reg && !advance;

    always_comb
    begin
        s1_valid_next  = in_stall ? s1_valid_reg : in_valid;
        out_valid_next = advance ? 1'b1 : (out_valid_reg && out_stall);
    end

    // nearest request at or above, and at or below, the current floor
    always_comb
    begin
        for (int i = 0; i < REQ; i++)
        begin
            ge_mask[i] = pending_reg[i] && (elev_pkg::floor_t'(i) >= floor_reg);
            le_mask[i] = pending_reg[i] && (elev_pkg::floor_t'(i) <= floor_reg);
        end
        above_hit   = |ge_mask;
        below_hit   = |le_mask;
        above_floor = '0;
        below_floor = '0;
        // descending scan: lowest set bit wins
        for (int i = REQ - 1; i >= 0; i--)
        begin
            if (ge_mask[i])
            begin
                above_floor = elev_pkg::floor_t'(i);
            end
        end
        // ascending scan: highest set bit wins
        for (int i = 0; i < REQ; i++)
        begin
            if (le_mask[i])
            begin
                below_floor = elev_pkg::floor_t'(i);
            end
        end
        dist_up = above_floor - floor_reg;
        dist_dn = floor_reg - below_floor;

        // moving: keep going if something lies ahead, else the other side
        // idle: nearest overall, a tie goes to the higher floor
        case (dir_reg)
            elev_pkg::DIR_UP:   pick_above = above_hit;
            elev_pkg::DIR_DOWN: pick_above = !below_hit;
            default:            pick_above = above_hit && (!below_hit || dist_up <= dist_dn);
        endcase
    end

    // state update and result word
    always_comb
    begin
        pending_next = pending_reg;
        floor_next   = floor_reg;
        dir_next     = dir_reg;
        opened_next  = 1'b0;
        found_next   = 1'b0;
        target_next  = '0;

        if (s1_cmd_reg == elev_pkg::CMD_CALL)
        begin
            for (int i = 0; i < REQ; i++)
            begin
                if (s1_call_reg == elev_pkg::floor_t'(i))
                begin
                    pending_next[i] = 1'b1;
                end
            end
        end
        else if (!above_hit && !below_hit)
        begin
            dir_next = elev_pkg::DIR_IDLE;
        end
        else
        begin
            found_next  = 1'b1;
            target_next = pick_above ? above_floor : below_floor;
            if (target_next == floor_reg)
            begin
                opened_next = 1'b1;
                for (int i = 0; i < REQ; i++)
                begin
                    if (floor_reg == elev_pkg::floor_t'(i))
                    begin
                        pending_next[i] = 1'b0;
                    end
                end
            end
            else if (target_next > floor_reg)
            begin
                dir_next   = elev_pkg::DIR_UP;
                floor_next = floor_reg + elev_pkg::floor_t'(1);
            end
            else
            begin
                dir_next   = elev_pkg::DIR_DOWN;
                floor_next = floor_reg - elev_pkg::floor_t'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            pending_reg   <= '0;
            floor_reg     <= '0;
            dir_reg       <= elev_pkg::DIR_IDLE;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance)
            begin
                pending_reg <= pending_next;
                floor_reg   <= floor_next;
                dir_reg     <= dir_next;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (!in_stall)
        begin
            s1_cmd_reg  <= elev_pkg::cmd_t'(command);
            s1_call_reg <= call_floor;
        end
        if (advance)
        begin
            opened_reg <= opened_next;
            found_reg  <= found_next;
            target_reg <= target_next;
        end
    end

    // floor and direction are reported as left by the word just completed
    assign out_valid    = out_valid_reg;
    assign car_floor    = floor_reg;
    assign travel_dir   = dir_reg;
    assign doors_opened = opened_reg;
    assign target_valid = found_reg;
    assign target_floor = target_reg;

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// self-checking bench for elevator_nearest_request_scheduler_top: directed and random
// call/step words, per-field comparison against a cycle-free car model; uses elev_pkg
module tb_top;

    localparam int FLOORS       = 16;
    localparam int QUIET_LIMIT  = 2000;   // cycles with no accepted word before giving up
    localparam int DRAIN_CYCLES = 8;      // settle time after the last expected word
    localparam int RANDOM_WORDS = 500;
    localparam int MAX_REPORTS  = 10;

    // one output word as the block should present it
    typedef struct
    {
        elev_pkg::floor_t car_floor;
        elev_pkg::dir_t   travel_dir;
        logic             doors_opened;
        logic             target_valid;
        elev_pkg::floor_t target_floor;
    } car_report_t;

    // car model plus the words still owed by the block
    class car_board;
        logic [FLOORS-1:0] req_map;
        elev_pkg::floor_t  at_floor;
        elev_pkg::dir_t    dir;
        car_report_t       reports_due[$];
        int                mismatches;

        function new();
            req_map    = '0;
            at_floor   = '0;
            dir        = elev_pkg::DIR_IDLE;
            mismatches = 0;
        endfunction

        function int gap_of(int a, int b);
            return (a > b) ? a - b : b - a;
        endfunction

        // advance the car model by one accepted input word
        function void note_event(elev_pkg::cmd_t cmd, elev_pkg::floor_t fl);
            car_report_t r;
            int          cur;
            int          tgt;
            int          stride;
            bit          hit;
            cur    = at_floor;
            tgt    = 0;
            hit    = 1'b0;
            stride = (dir == elev_pkg::DIR_UP) ? 1 : -1;
            r.doors_opened = 1'b0;
            if (cmd == elev_pkg::CMD_CALL)
            begin
                if (fl < FLOORS)
                    req_map[fl] = 1'b1;
            end
            else
            begin
                // direction priority: nearest request ahead, current floor included
                if (dir != elev_pkg::DIR_IDLE)
                begin
                    for (int i = cur; i >= 0 && i < FLOORS && !hit; i += stride)
                    begin
                        if (req_map[i])
                        begin
                            hit = 1'b1;
                            tgt = i;
                        end
                    end
                end
                // nearest overall, ties to the higher floor
                if (!hit)
                begin
                    for (int i = 0; i < FLOORS; i++)
                    begin
                        if (req_map[i] && (!hit || gap_of(i, cur) <= gap_of(tgt, cur)))
                        begin
                            hit = 1'b1;
                            tgt = i;
                        end
                    end
                end
                if (!hit)
                    dir = elev_pkg::DIR_IDLE;
                else if (tgt == cur)
                begin
                    req_map[tgt]   = 1'b0;
                    r.doors_opened = 1'b1;
                end
                else
                begin
                    dir      = (tgt > cur) ? elev_pkg::DIR_UP : elev_pkg::DIR_DOWN;
                    at_floor = (tgt > cur) ? elev_pkg::floor_t'(cur + 1)
                                           : elev_pkg::floor_t'(cur - 1);
                end
            end
            r.car_floor    = at_floor;
            r.travel_dir   = dir;
            r.target_valid = hit;
            r.target_floor = hit ? elev_pkg::floor_t'(tgt) : elev_pkg::floor_t'(0);
            reports_due.push_back(r);
        endfunction

        // compare one accepted output word with the oldest owed word
        function void check_report(elev_pkg::floor_t cf, elev_pkg::dir_t td, logic dop,
                                   logic tv, elev_pkg::floor_t tf);
            car_report_t e;
            if (reports_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected word: floor %0d dir %0d doors %0b tv %0b tgt %0d",
                             cf, td, dop, tv, tf);
                return;
            end
            e = reports_due.pop_front();
            if (cf !== e.car_floor || td !== e.travel_dir || dop !== e.doors_opened ||
                tv !== e.target_valid || tf !== e.target_floor)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("mismatch (exp/act): floor %0d/%0d dir %0d/%0d",
                             e.car_floor, cf, e.travel_dir, td,
                             " doors %0b/%0b tv %0b/%0b tgt %0d/%0d",
                             e.doors_opened, dop, e.target_valid, tv, e.target_floor, tf);
            end
        endfunction

        function int owed();
            return reports_due.size();
        endfunction
    endclass

    // clock, reset and block ports; every input known from time zero
    logic             clk        = 1'b0;
    logic             rst_n      = 1'b0;
    logic             in_valid   = 1'b0;
    logic             in_stall;
    logic             command    = elev_pkg::CMD_STEP;
    elev_pkg::floor_t call_floor = '0;
    logic             out_valid;
    logic             out_stall  = 1'b0;
    elev_pkg::floor_t car_floor;
    elev_pkg::dir_t   travel_dir;
    logic             doors_opened;
    logic             target_valid;
    elev_pkg::floor_t target_floor;

    // idling mode: 0 none, 1 sender idles, 2 receiver stalls, 3 both lightly
    int       idle_mode   = 0;
    int       quiet_cycles = 0;
    car_board board        = new();

    elevator_nearest_request_scheduler_top #(
        .FLOORS(FLOORS)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .command     (command),
        .call_floor  (call_floor),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .car_floor   (car_floor),
        .travel_dir  (travel_dir),
        .doors_opened(doors_opened),
        .target_valid(target_valid),
        .target_floor(target_floor)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // chance in percent that the sender sits out a cycle
    function bit sender_idles();
        case (idle_mode)
            1:       return $urandom_range(0, 99) < 61;
            3:       return $urandom_range(0, 99) < 12;
            default: return 1'b0;
        endcase
    endfunction

    // chance in percent that the receiver holds off a word
    function bit receiver_stalls();
        case (idle_mode)
            2:       return $urandom_range(0, 99) < 61;
            3:       return $urandom_range(0, 99) < 12;
            default: return 1'b0;
        endcase
    endfunction

    // present one word, hold it until taken, then note it in the car model
    // entered right after an edge at which the channel became free
    task automatic send_word(input elev_pkg::cmd_t cmd, input elev_pkg::floor_t fl);
        while (sender_idles())
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        command    <= cmd;
        call_floor <= fl;
        @(posedge clk);
        // values read here are the ones the block saw at this edge
        while (in_stall)
            @(posedge clk);
        board.note_event(cmd, fl);
    endtask

    task automatic send_call(input int fl);
        send_word(elev_pkg::CMD_CALL, elev_pkg::floor_t'(fl));
    endtask

    task automatic send_step();
        // the floor field is don't-care on a step, so let it wander
        send_word(elev_pkg::CMD_STEP, elev_pkg::floor_t'($urandom_range(0, FLOORS - 1)));
    endtask

    // receiver: check each taken word, then choose the stall for the next edge
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            board.check_report(car_floor, travel_dir, doors_opened, target_valid,
                               target_floor);
        out_stall <= receiver_stalls();
    end

    // count cycles in which neither channel moves a word
    always @(posedge clk)
    begin
        if (!rst_n)
            quiet_cycles <= 0;
        else if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // watchdog: a hung handshake ends the run
    initial
    begin
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part, no idling
        idle_mode = 0;
        send_step();            // empty bitmap: car stays idle at floor 0
        send_call(0);
        send_step();            // call on the current floor while idle: doors open
        send_call(2);
        send_step();            // heads up toward floor 2
        send_step();
        send_step();            // serves 2, direction kept
        send_step();            // nothing left: back to idle at floor 2
        send_call(0);
        send_call(4);
        send_step();            // equal distance both ways: the higher floor wins
        send_step();
        send_step();            // serves 4 while heading up
        send_step();            // nothing ahead: falls back to floor 0, turns down
        send_call(5);
        send_call(15);          // top floor
        send_step();            // heading down ignores the nearer call above
        send_call(2);
        send_step();            // floor under the car counts as ahead: served
        send_call(2);
        send_call(2);           // repeated call on the same floor
        send_step();
        send_call(0);
        send_step();

        // random part: calls and steps mixed, idling mode rotates every 50 words
        for (int n = 0; n < RANDOM_WORDS; n++)
        begin
            idle_mode = (n / 50) % 4;
            if ($urandom_range(0, 99) < 30)
                send_call($urandom_range(0, FLOORS - 1));
            else
                send_step();
        end
        in_valid <= 1'b0;

        // drain: every owed word back, then a few more edges for stray ones
        while (board.owed() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (board.mismatches == 0 && board.owed() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
